// ===== rtl/core/kwm_pkg.sv =====
// kwm_pkg: shared types and constants of the k-way sorted run merger.
// No dependencies; imported by every file of the block.
package kwm_pkg;

  localparam int unsigned ValW   = 64;  // element width
  localparam int unsigned RunW   = 4;   // run number field width
  localparam int unsigned CntW   = 5;   // run_count register width
  localparam int unsigned TdataW = 72;  // {run, value} packed, padded to bytes

  localparam logic [CntW-1:0] RunCountRst = 5'd16;

  // Comparison token travelling down the cell row
  typedef struct packed {
    logic            vld;  // token present in this stage
    logic            any;  // some active head seen so far
    logic            rdy;  // no active run seen waiting for a refill
    logic [ValW-1:0] val;  // smallest head so far
  } tok_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic active;  // run index below the run count
    logic ld;      // incoming word addresses this run
    logic clr;     // this head is being emitted
  } cell_ctl_t;

  // Per-cell status back to the sequencer
  typedef struct packed {
    logic last;  // held head is the run's final element
    logic exh;   // run has delivered its final element
  } cell_sts_t;

endpackage

// ===== rtl/core/k_way_sorted_run_merger_core.sv =====
// k_way_sorted_run_merger_core: top level, sequencer, output register.
// Depends on kwm_pkg and kwm_cell.
//
//  channel    | dir | handshake                   | payload
//  -----------+-----+-----------------------------+------------------------------------
//  s_axis     | in  | s_axis_tvalid/s_axis_tready | run_index, element_value; tlast
//  m_axis     | out | m_axis_tvalid/m_axis_tready | merged_value, source_run; tlast
//  run_count  | in  | run_count_we_i              | run_count (5 bits)
//
// Sequence: a word is taken, then a compare token walks the cell row, one cell
//   per cycle, and a decide step follows the scan. When the emitted head was
//   its run's last, a further scan is started to look for the next emission.
// Stalls: the result sits in an output register; a scan that finishes while
//   it is still unread waits in the decide step. s_axis_tready is high only
//   between scans.
// Reset: asynchronous, clears all head flags; run_count returns to 16.
module k_way_sorted_run_merger_core #(
  parameter int unsigned MAX_RUNS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // run_count register
  input  logic        run_count_we_i,
  input  logic [kwm_pkg::CntW-1:0] run_count_wdata_i,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [kwm_pkg::TdataW-1:0] s_axis_tdata,  // [3:0] run_index, [67:4] element_value
  input  logic        s_axis_tlast,                  // last_in_run
  // merged words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [kwm_pkg::TdataW-1:0] m_axis_tdata,  // [63:0] merged_value, [67:64] source_run
  output logic        m_axis_tlast                   // final_element
);
  import kwm_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_RUNS);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SWEEP  = 3'b010,
    ST_DECIDE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0] run_count_q;
  logic            start_q, start_d;
  logic            in_acc;
  logic            out_free;
  logic            emit;

  // captured scan result
  tok_t            res_q;
  logic [IdxW-1:0] res_idx_q;

  // output register
  logic            m_vld_q, m_vld_d;
  logic [ValW-1:0] m_val_q;
  logic [RunW-1:0] m_run_q;
  logic            m_last_q;

  // cell row wiring
  tok_t            tok_w [MAX_RUNS+1];
  logic [IdxW-1:0] idx_w [MAX_RUNS+1];
  cell_ctl_t       ctl   [MAX_RUNS];
  cell_sts_t       sts   [MAX_RUNS];
  logic [MAX_RUNS-1:0] exh_after;
  logic [MAX_RUNS-1:0] act_vec;
  logic            best_last;
  logic            all_done;

  logic [RunW-1:0] in_run;
  logic [ValW-1:0] in_val;

  assign in_run = s_axis_tdata[RunW-1:0];
  assign in_val = s_axis_tdata[RunW +: ValW];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_vld_q || m_axis_tready;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_count_q <= RunCountRst;
    end else if (run_count_we_i) begin
      run_count_q <= run_count_wdata_i;
    end
  end

  // token injected at the head of the row: nothing seen yet
  assign tok_w[0].vld = start_q;
  assign tok_w[0].any = 1'b0;
  assign tok_w[0].rdy = 1'b1;
  assign tok_w[0].val = '0;
  assign idx_w[0]     = '0;

  for (genvar k = 0; k < MAX_RUNS; k++) begin : g_cell
    // run_count never exceeds 31, so this also caps the count at MAX_RUNS
    assign act_vec[k]    = (int'(run_count_q) > k);
    assign ctl[k].active = act_vec[k];
    assign ctl[k].ld     = in_acc && (int'(in_run) == k);
    assign ctl[k].clr    = emit && (int'(res_idx_q) == k);

    kwm_cell #(
      .IdxW (IdxW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl[k]),
      .ld_value_i (in_val),
      .ld_last_i  (s_axis_tlast),
      .cell_id_i  (IdxW'(k)),
      .tok_i      (tok_w[k]),
      .tok_idx_i  (idx_w[k]),
      .tok_o      (tok_w[k+1]),
      .tok_idx_o  (idx_w[k+1]),
      .sts_o      (sts[k])
    );

    // exhaustion as it stands once the chosen head has left
    assign exh_after[k] = sts[k].exh || ((int'(res_idx_q) == k) && sts[k].last);
  end

  assign best_last = sts[res_idx_q].last;
  assign all_done  = &(exh_after | ~act_vec);

  // emit in the decide step when every active run is held or exhausted, a head exists and the output is free
  assign emit = (state_q == ST_DECIDE) && res_q.rdy && res_q.any && out_free;

  always_comb begin
    state_d = state_q;
    start_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_SWEEP;
          start_d = 1'b1;
        end
      end
      ST_SWEEP: begin
        if (tok_w[MAX_RUNS].vld) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!(res_q.rdy && res_q.any)) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          // a run just ran dry: the others may still be ready, scan again
          if (best_last) begin
            state_d = ST_SWEEP;
            start_d = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SWEEP && tok_w[MAX_RUNS].vld) begin
      res_q     <= tok_w[MAX_RUNS];
      res_idx_q <= idx_w[MAX_RUNS];
    end
  end

  // output register
  always_comb begin
    m_vld_d = m_vld_q;
    if (emit) begin
      m_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      m_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_val_q  <= res_q.val;
      m_run_q  <= RunW'(res_idx_q);
      m_last_q <= all_done;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = {{(TdataW - ValW - RunW){1'b0}}, m_run_q, m_val_q};
  assign m_axis_tlast  = m_last_q;

endmodule

// ===== rtl/core/kwm_cell.sv =====
// kwm_cell: one run's head register plus one stage of the compare chain.
// Depends on kwm_pkg.
module kwm_cell #(
  parameter int unsigned IdxW = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kwm_pkg::cell_ctl_t ctl_i,
  input  logic [kwm_pkg::ValW-1:0] ld_value_i,
  input  logic              ld_last_i,
  input  logic [IdxW-1:0]   cell_id_i,
  input  kwm_pkg::tok_t     tok_i,
  input  logic [IdxW-1:0]   tok_idx_i,
  output kwm_pkg::tok_t     tok_o,
  output logic [IdxW-1:0]   tok_idx_o,
  output kwm_pkg::cell_sts_t sts_o
);
  import kwm_pkg::*;

  logic [ValW-1:0] value_q;
  logic            present_q, last_q, exh_q;
  tok_t            tok_d, tok_q;
  logic [IdxW-1:0] idx_d, idx_q;
  logic            take;
  logic            load;

  assign load = ctl_i.ld && ctl_i.active && !present_q && !exh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      last_q    <= 1'b0;
      exh_q     <= 1'b0;
    end else if (load) begin
      present_q <= 1'b1;
      last_q    <= ld_last_i;
    end else if (ctl_i.clr) begin
      present_q <= 1'b0;
      if (last_q) begin
        exh_q  <= 1'b1;
        last_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      value_q <= ld_value_i;
    end
  end

  // strict less-than keeps ties with the lower run upstream
  assign take = !tok_i.any || (value_q < tok_i.val);

  always_comb begin
    tok_d = tok_i;
    idx_d = tok_idx_i;
    if (ctl_i.active && present_q) begin
      tok_d.any = 1'b1;
      if (take) begin
        tok_d.val = value_q;
        idx_d     = cell_id_i;
      end
    end else if (ctl_i.active && !exh_q) begin
      tok_d.rdy = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  assign tok_o      = tok_q;
  assign tok_idx_o  = idx_q;
  assign sts_o.last = last_q;
  assign sts_o.exh  = exh_q;

endmodule

// ===== rtl/core/kwm_checker.sv =====
// kwm_checker: port-level checks of the merger, bound to the top level.
// Depends on kwm_pkg and k_way_sorted_run_merger_core.
module kwm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic run_count_we_i,
  input logic [kwm_pkg::CntW-1:0] run_count_wdata_i,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic [kwm_pkg::TdataW-1:0] s_axis_tdata,
  input logic s_axis_tlast,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [kwm_pkg::TdataW-1:0] m_axis_tdata,
  input logic m_axis_tlast
);
  import kwm_pkg::*;

  // a taken word starts a scan: no second word in the next cycle
  a_busy_after_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a scan is running");

  // a result needs a full scan, so none appears right after a word is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
    else $error("result without a scan");

  // after the final word no new result follows at once
  a_final_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("result straight after the final word");

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output word changed while stalled");

endmodule

bind k_way_sorted_run_merger_core kwm_checker u_kwm_checker (.*);
